// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPD_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define LPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/lpd_pkg.sv -----
// types and constants of the length prefixed deframer
`timescale 1ns / 1ps

package lpd_pkg;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 3;
   localparam int LEN_W       = 32;
   localparam int CNT_W       = 32;
   localparam int MAX_LEN_W   = 16;
   localparam int LEN_BYTES   = LEN_W / BYTE_W;
   localparam int REQ_TDATA_W = BYTE_W;
   localparam int RSP_TDATA_W = BYTE_W + LEN_W + CNT_W + CNT_W;

   // defaults
   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'd512;
   localparam int HEADER_BYTES_DEFAULT = 4;

   // result classification
   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER   = 3'd0,
      KIND_PAYLOAD  = 3'd1,
      KIND_SKIP     = 3'd2,
      KIND_OVERSIZE = 3'd3,
      KIND_EMPTY    = 3'd4,
      KIND_HDR_DONE = 3'd5,
      KIND_RESTART  = 3'd6
   } kind_type;

   // one result word
   typedef struct packed {
      kind_type              kind;
      logic [BYTE_W-1:0]     payload_byte;
      logic                  last;
      logic [LEN_W-1:0]      message_length;
      logic [CNT_W-1:0]      delivered_count;
      logic [CNT_W-1:0]      oversize_count;
   } result_type;

endpackage

// ----- sv/lpd_core.sv -----
// framing state, message counters and per-word classification
`timescale 1ns / 1ps

module lpd_core #(
   parameter int HEADER_BYTES = lpd_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [lpd_pkg::BYTE_W-1:0]        data_byte,
   input  logic                              restart,
   input  logic [lpd_pkg::MAX_LEN_W-1:0]     max_length,
   output lpd_pkg::result_type               result
);

   localparam int HC_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam logic [HC_W-1:0] HC_LAST = HC_W'(HEADER_BYTES - 1);

   logic [HC_W-1:0]               hdr_count_ff, hdr_count_in;
   logic [lpd_pkg::LEN_W-1:0]     declared_ff, declared_in;
   logic [lpd_pkg::LEN_W-1:0]     pay_rem_ff, pay_rem_in;
   logic [lpd_pkg::LEN_W-1:0]     skip_rem_ff, skip_rem_in;
   logic [lpd_pkg::CNT_W-1:0]     delivered_ff, delivered_in;
   logic [lpd_pkg::CNT_W-1:0]     oversize_ff, oversize_in;
   logic [lpd_pkg::LEN_W-1:0]     hdr_len;

   // length with this word placed in its byte lane; first header byte starts fresh
   always_comb begin
      hdr_len = (hdr_count_ff == '0) ? '0 : declared_ff;
      for (int i = 0; i < lpd_pkg::LEN_BYTES; i++) begin
         if (int'(hdr_count_ff) == i) begin
            hdr_len[i*lpd_pkg::BYTE_W +: lpd_pkg::BYTE_W] = data_byte;
         end
      end
   end

   // next state and result for the word at the input
   always_comb begin
      hdr_count_in = hdr_count_ff;
      declared_in  = declared_ff;
      pay_rem_in   = pay_rem_ff;
      skip_rem_in  = skip_rem_ff;
      delivered_in = delivered_ff;
      oversize_in  = oversize_ff;
      result.kind           = lpd_pkg::KIND_HEADER;
      result.payload_byte   = '0;
      result.last           = 1'b0;
      result.message_length = '0;

      if (restart) begin
         hdr_count_in = '0;
         declared_in  = '0;
         pay_rem_in   = '0;
         skip_rem_in  = '0;
         result.kind  = lpd_pkg::KIND_RESTART;
      end else if (skip_rem_ff != '0) begin
         skip_rem_in           = skip_rem_ff - 1'b1;
         result.kind           = lpd_pkg::KIND_SKIP;
         result.message_length = declared_ff;
      end else if (pay_rem_ff != '0) begin
         pay_rem_in            = pay_rem_ff - 1'b1;
         result.kind           = lpd_pkg::KIND_PAYLOAD;
         result.payload_byte   = data_byte;
         result.message_length = declared_ff;
         if (pay_rem_ff == lpd_pkg::LEN_W'(1)) begin
            result.last  = 1'b1;
            delivered_in = delivered_ff + 1'b1;
         end
      end else begin
         declared_in = hdr_len;
         if (hdr_count_ff != HC_LAST) begin
            hdr_count_in = hdr_count_ff + 1'b1;
            result.kind  = lpd_pkg::KIND_HEADER;
         end else begin
            hdr_count_in = '0;
            if (hdr_len > {{(lpd_pkg::LEN_W - lpd_pkg::MAX_LEN_W){1'b0}}, max_length}) begin
               oversize_in           = oversize_ff + 1'b1;
               skip_rem_in           = hdr_len;
               result.kind           = lpd_pkg::KIND_OVERSIZE;
               result.message_length = hdr_len;
            end else if (hdr_len == '0) begin
               result.kind = lpd_pkg::KIND_EMPTY;
            end else begin
               pay_rem_in            = hdr_len;
               result.kind           = lpd_pkg::KIND_HDR_DONE;
               result.message_length = hdr_len;
            end
         end
      end

      result.delivered_count = delivered_in;
      result.oversize_count  = oversize_in;
   end

   // state registers, advanced once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_count_ff <= '0;
         declared_ff  <= '0;
         pay_rem_ff   <= '0;
         skip_rem_ff  <= '0;
         delivered_ff <= '0;
         oversize_ff  <= '0;
      end else if (accept) begin
         hdr_count_ff <= hdr_count_in;
         declared_ff  <= declared_in;
         pay_rem_ff   <= pay_rem_in;
         skip_rem_ff  <= skip_rem_in;
         delivered_ff <= delivered_in;
         oversize_ff  <= oversize_in;
      end
   end

endmodule

// ----- sv/length_prefixed_deframer.sv -----
// top level of the length prefixed deframer
`timescale 1ns / 1ps
//
// Splits a byte stream into messages framed as a HEADER_BYTES little-endian
// length followed by that many payload bytes.
// req: one stream byte per word (tdata), tuser high restarts the framing and
// the byte is dropped. rsp: one word per accepted req word, classifying it
// (tuser kind), with payload byte, message length and the two message
// counters in tdata; tlast marks the final payload byte of a message.
// csr: a write sets max_length; longer messages are counted and skipped.
// The result word is registered in the output register, or first in the skid
// register while rsp stalls. Throughput: one word per cycle while the skid
// register is empty; the framing core updates its state once per accepted word.
// Reset clears framing state and both counters and sets max_length to 512.
// When rsp stalls, one more req word is held in a skid register, after which
// req_tready drops until rsp_tready returns; nothing is lost or repeated.
//
module length_prefixed_deframer #(
   parameter int HEADER_BYTES = lpd_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: data_byte [7:0]
   input  logic [lpd_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // req_tuser: restart [0]
   input  logic                                 req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: payload_byte [7:0], message_length [39:8],
   // delivered_count [71:40], oversize_count [103:72]
   output logic [lpd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // rsp_tuser: kind [2:0]
   output logic [lpd_pkg::KIND_W-1:0]           rsp_tuser,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_wr_en,
   input  logic [lpd_pkg::MAX_LEN_W-1:0]        csr_wr_data
);

   logic [lpd_pkg::MAX_LEN_W-1:0] max_len_ff;
   lpd_pkg::result_type           core_result;
   lpd_pkg::result_type           rsp_ff, rsp_in;
   lpd_pkg::result_type           skid_ff, skid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          skid_valid_ff, skid_valid_in;
   logic                          accept;
   logic                          rsp_free;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // framing core
   lpd_core #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_tdata),
      .restart    (req_tuser),
      .max_length (max_len_ff),
      .result     (core_result)
   );

   // output register and skid stage steering
   always_comb begin
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = core_result;
            rsp_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = core_result;
         skid_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= lpd_pkg::MAX_LEN_RESET;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {rsp_ff.oversize_count, rsp_ff.delivered_count,
                        rsp_ff.message_length, rsp_ff.payload_byte};

endmodule

// ----- sv/lpd_checker.sv -----
// port-level checks of the length prefixed deframer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic [lpd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input logic [lpd_pkg::KIND_W-1:0]           rsp_tuser,
   input logic                                 rsp_tlast,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready
);

   logic stalled;
   logic tail_zero;

   assign stalled   = rsp_tvalid && !rsp_tready;
   assign tail_zero = (rsp_tdata[lpd_pkg::BYTE_W-1:0] == '0);

   // a stalled word holds
   `LPD_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // end of message only on a payload word
   `LPD_ASSERT(a_last_payload, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == lpd_pkg::KIND_PAYLOAD)

   // payload byte field is zero on any other kind
   `LPD_ASSERT(a_byte_zero, clock, reset, rsp_tvalid && rsp_tuser != lpd_pkg::KIND_PAYLOAD, tail_zero)

   // input blocked means the skid is full, so the output must hold a word
   `LPD_ASSERT(a_skid_full, clock, reset, !req_tready, rsp_tvalid)

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
